// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty bodies when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define AST_ON(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_ON(lbl, clk, rst_n, prop)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/abp_pkg.sv =====
// ----------------------------------------------------------------------------
// abp_pkg
// Shared constants, class codes and the per-block step record.
// ----------------------------------------------------------------------------
package abp_pkg;

  // Defaults of the top level parameters
  localparam int ADDR_BITS_DEF  = 48;
  localparam int PAGE_SHIFT_DEF = 12;

  // Fixed field widths
  localparam int ORDER_W = 6;
  localparam int CLASS_W = 2;
  localparam int TOTAL_W = 52;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VICE_MIN = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] MAIN_MIN_RST = 6'd14;
  localparam logic [CFG_W-1:0] VICE_MIN_RST = 6'd10;

  // Limits per segment
  localparam int MAX_BLOCKS = 56;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LOOP_BOUND = 136;
  localparam int ITER_W     = $clog2(LOOP_BOUND + 1);

  // Depth of the plan queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Block classes
  localparam logic [CLASS_W-1:0] CLS_MAIN = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_VICE = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_NONE = 2'd2;

  // Outcome of one cutting step
  typedef struct packed {
    logic               fits;   // at least one page left
    logic [ORDER_W-1:0] order;
    logic [CLASS_W-1:0] cls;
  } blk_info_t;

endpackage

// ===== hdl/abp_step.sv =====
// ----------------------------------------------------------------------------
// abp_step
// One cutting step: picks the largest aligned block at the cursor that fits
// in the remainder, classes it and advances cursor and remainder.
// ----------------------------------------------------------------------------
module abp_step #(
  parameter int ADDR_BITS  = abp_pkg::ADDR_BITS_DEF,
  parameter int PAGE_SHIFT = abp_pkg::PAGE_SHIFT_DEF
) (
  input  logic [ADDR_BITS-1:0]          cur,
  input  logic [ADDR_BITS-1:0]          rem,
  input  logic [abp_pkg::CFG_W-1:0]     main_min,
  input  logic [abp_pkg::CFG_W-1:0]     vice_min,
  output abp_pkg::blk_info_t            info,
  output logic [ADDR_BITS-1:0]          nxt_cur,
  output logic [ADDR_BITS-1:0]          nxt_rem
);

  localparam int IDX_W = $clog2(ADDR_BITS);
  localparam logic [IDX_W-1:0] PS = IDX_W'(PAGE_SHIFT);
  localparam int ORDER_W_L = abp_pkg::ORDER_W;

  function automatic logic [IDX_W-1:0] onehot_idx(input logic [ADDR_BITS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      if (v[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

  logic [ADDR_BITS-1:0] cur_low;
  logic [ADDR_BITS-1:0] rem_rev;
  logic [ADDR_BITS-1:0] rev_low;
  logic [ADDR_BITS-1:0] rem_top;
  logic [ADDR_BITS-1:0] blk_size;
  logic [IDX_W-1:0]     idx_a;
  logic [IDX_W-1:0]     idx_t;
  logic [IDX_W-1:0]     ord_a;
  logic [IDX_W-1:0]     ord_t;
  logic [IDX_W-1:0]     ord_sel;
  logic [ORDER_W_L-1:0] ord_out;

  // Isolate lowest set bit of the cursor (its alignment)
  assign cur_low = cur & (~cur + 1'b1);

  // Isolate highest set bit of the remainder through a bit reversal
  always_comb begin
    for (int i = 0; i < ADDR_BITS; i++) begin
      rem_rev[i] = rem[ADDR_BITS-1-i];
    end
  end
  assign rev_low = rem_rev & (~rem_rev + 1'b1);
  always_comb begin
    for (int i = 0; i < ADDR_BITS; i++) begin
      rem_top[i] = rev_low[ADDR_BITS-1-i];
    end
  end

  assign idx_a = onehot_idx(cur_low);
  assign idx_t = onehot_idx(rem_top);

  // Alignment order (zero for a zero or sub-page aligned cursor), fit order
  assign ord_a   = (idx_a > PS) ? idx_a - PS : '0;
  assign ord_t   = idx_t - PS;
  assign ord_sel = (ord_a <= ord_t) ? ord_a : ord_t;
  assign ord_out = ORDER_W_L'(ord_sel);

  assign blk_size = {{(ADDR_BITS-1){1'b0}}, 1'b1} << (ord_sel + PS);

  // Class the block, main test first
  always_comb begin
    info.fits  = |rem[ADDR_BITS-1:PAGE_SHIFT];
    info.order = ord_out;
    if (ord_out >= main_min) begin
      info.cls = abp_pkg::CLS_MAIN;
    end else if (ord_out >= vice_min) begin
      info.cls = abp_pkg::CLS_VICE;
    end else begin
      info.cls = abp_pkg::CLS_NONE;
    end
  end

  assign nxt_cur = cur + blk_size;
  assign nxt_rem = rem - blk_size;

endmodule

// ===== hdl/abp_queue.sv =====
// ----------------------------------------------------------------------------
// abp_queue
// Short FIFO of segment plans between the planning front and the emitting
// back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = abp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `AST_ON(a_no_push_full, clk, rst_n, push |-> !full)
  `AST_ON(a_no_pop_empty, clk, rst_n, pop |-> !empty)
  `AST_ON(a_count_range, clk, rst_n, count_r <= CNT_W'(DEPTH))

endmodule

// ===== hdl/abp_front.sv =====
// ----------------------------------------------------------------------------
// abp_front
// Takes segments, clips them to the address space, walks the block cut once
// to count kept blocks and track the smallest main block, keeps the byte
// total and hands a segment plan to the queue.
// ----------------------------------------------------------------------------
module abp_front #(
  parameter int ADDR_BITS  = abp_pkg::ADDR_BITS_DEF,
  parameter int PAGE_SHIFT = abp_pkg::PAGE_SHIFT_DEF,
  parameter int DESC_W     = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      seg_valid,
  output logic                      seg_ready,
  input  logic [ADDR_BITS-1:0]      seg_base,
  input  logic [ADDR_BITS-1:0]      seg_size,
  input  logic                      seg_last,
  input  logic [abp_pkg::CFG_W-1:0] main_min,
  input  logic [abp_pkg::CFG_W-1:0] vice_min,
  output logic                      q_push,
  input  logic                      q_full,
  output logic [DESC_W-1:0]         q_wdata
);

  localparam int TOTAL_W = abp_pkg::TOTAL_W;
  localparam int ORDER_W = abp_pkg::ORDER_W;
  localparam int CNT_W   = abp_pkg::CNT_W;
  localparam int ITER_W  = abp_pkg::ITER_W;
  localparam int SUM_W   = ((ADDR_BITS > TOTAL_W) ? ADDR_BITS : TOTAL_W) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] rem;
    logic [CNT_W-1:0]     n_kept;
    logic [TOTAL_W-1:0]   total;
    logic                 best_valid;
    logic [ADDR_BITS-1:0] best_base;
    logic [ORDER_W-1:0]   best_order;
  } desc_t;

  logic [1:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] cur_r, cur_nxt;
  logic [ADDR_BITS-1:0] rem_r, rem_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [ADDR_BITS-1:0] rem0_r, rem0_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [ITER_W-1:0]    it_r, it_nxt;
  logic                 last_r, last_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 best_valid_r, best_valid_nxt;
  logic [ADDR_BITS-1:0] best_base_r, best_base_nxt;
  logic [ORDER_W-1:0]   best_order_r, best_order_nxt;

  abp_pkg::blk_info_t   info;
  logic [ADDR_BITS-1:0] step_cur;
  logic [ADDR_BITS-1:0] step_rem;
  logic [ADDR_BITS:0]   end_sum;
  logic [ADDR_BITS-1:0] clip_rem;
  logic                 skip;
  logic [SUM_W-1:0]     sum;
  logic [TOTAL_W-1:0]   total_sat;
  logic                 better;
  logic                 walk_done;
  desc_t                desc;

  abp_step #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_step (
    .cur      (cur_r),
    .rem      (rem_r),
    .main_min (main_min),
    .vice_min (vice_min),
    .info     (info),
    .nxt_cur  (step_cur),
    .nxt_rem  (step_rem)
  );

  // Clip the segment at the top of the address space
  assign end_sum  = {1'b0, seg_base} + {1'b0, seg_size};
  assign clip_rem = end_sum[ADDR_BITS] ? (~seg_base + 1'b1) : seg_size;

  // Drop an unaligned segment unless order zero blocks are kept
  assign skip = (|seg_base[PAGE_SHIFT-1:0]) && (main_min != '0) && (vice_min != '0);

  // Saturating byte total
  assign sum       = SUM_W'(total_r) + SUM_W'(seg_size);
  assign total_sat = (|sum[SUM_W-1:TOTAL_W]) ? '1 : sum[TOTAL_W-1:0];

  assign better = !best_valid_r || (info.order < best_order_r) ||
                  ((info.order == best_order_r) && (cur_r < best_base_r));

  assign walk_done = (it_r == ITER_W'(abp_pkg::LOOP_BOUND)) ||
                     (n_r == CNT_W'(abp_pkg::MAX_BLOCKS)) || !info.fits;

  assign seg_ready = (state_r == ST_IDLE);
  assign q_push    = (state_r == ST_PUSH) && !q_full;

  // Plan handed to the back
  always_comb begin
    desc.base       = base_r;
    desc.rem        = rem0_r;
    desc.n_kept     = n_r;
    desc.total      = total_r;
    desc.best_valid = best_valid_r;
    desc.best_base  = best_base_r;
    desc.best_order = best_order_r;
  end
  assign q_wdata = desc;

  // Sequence one segment: take, walk, hand over
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    base_nxt       = base_r;
    rem0_nxt       = rem0_r;
    n_nxt          = n_r;
    it_nxt         = it_r;
    last_nxt       = last_r;
    total_nxt      = total_r;
    best_valid_nxt = best_valid_r;
    best_base_nxt  = best_base_r;
    best_order_nxt = best_order_r;
    case (state_r)
      ST_IDLE: begin
        if (seg_valid) begin
          base_nxt  = seg_base;
          cur_nxt   = seg_base;
          rem_nxt   = skip ? '0 : clip_rem;
          rem0_nxt  = skip ? '0 : clip_rem;
          n_nxt     = '0;
          it_nxt    = '0;
          last_nxt  = seg_last;
          total_nxt = total_sat;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_PUSH;
        end else begin
          if (info.cls != abp_pkg::CLS_NONE) begin
            n_nxt = n_r + 1'b1;
            if ((info.cls == abp_pkg::CLS_MAIN) && better) begin
              best_valid_nxt = 1'b1;
              best_base_nxt  = cur_r;
              best_order_nxt = info.order;
            end
          end
          cur_nxt = step_cur;
          rem_nxt = step_rem;
          it_nxt  = it_r + 1'b1;
        end
      end
      ST_PUSH: begin
        if (!q_full) begin
          state_nxt = ST_IDLE;
          // End of map: clear the running state
          if (last_r) begin
            total_nxt      = '0;
            best_valid_nxt = 1'b0;
            best_base_nxt  = '0;
            best_order_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      best_valid_r <= 1'b0;
      best_base_r  <= '0;
      best_order_r <= '0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      best_valid_r <= best_valid_nxt;
      best_base_r  <= best_base_nxt;
      best_order_r <= best_order_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
    rem0_r <= rem0_nxt;
    n_r    <= n_nxt;
    it_r   <= it_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== hdl/abp_back.sv =====
// ----------------------------------------------------------------------------
// abp_back
// Replays the block cut of a planned segment and emits each kept block, with
// the segment's final total and best main block, through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abp_back #(
  parameter int ADDR_BITS  = abp_pkg::ADDR_BITS_DEF,
  parameter int PAGE_SHIFT = abp_pkg::PAGE_SHIFT_DEF,
  parameter int DESC_W     = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [DESC_W-1:0]           q_rdata,
  input  logic [abp_pkg::CFG_W-1:0]   main_min,
  input  logic [abp_pkg::CFG_W-1:0]   vice_min,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ADDR_BITS-1:0]        blk_base,
  output logic [abp_pkg::ORDER_W-1:0] blk_order,
  output logic [abp_pkg::CLASS_W-1:0] blk_class,
  output logic                        blk_last,
  output logic [abp_pkg::TOTAL_W-1:0] total_bytes,
  output logic                        first_valid,
  output logic [ADDR_BITS-1:0]        first_base,
  output logic [abp_pkg::ORDER_W-1:0] first_order
);

  localparam int TOTAL_W = abp_pkg::TOTAL_W;
  localparam int ORDER_W = abp_pkg::ORDER_W;
  localparam int CLASS_W = abp_pkg::CLASS_W;
  localparam int CNT_W   = abp_pkg::CNT_W;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_NONE = 2'd1;
  localparam logic [1:0] B_WALK = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] rem;
    logic [CNT_W-1:0]     n_kept;
    logic [TOTAL_W-1:0]   total;
    logic                 best_valid;
    logic [ADDR_BITS-1:0] best_base;
    logic [ORDER_W-1:0]   best_order;
  } desc_t;

  desc_t                d_in;
  logic [1:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] cur_r, cur_nxt;
  logic [ADDR_BITS-1:0] rem_r, rem_nxt;
  logic [ADDR_BITS-1:0] seg_base_r, seg_base_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     emit_r, emit_nxt;
  logic [TOTAL_W-1:0]   tot_r, tot_nxt;
  logic                 bv_r, bv_nxt;
  logic [ADDR_BITS-1:0] bb_r, bb_nxt;
  logic [ORDER_W-1:0]   bo_r, bo_nxt;

  // Output register
  logic                 ov_r, ov_nxt;
  logic [ADDR_BITS-1:0] ob_r, ob_nxt;
  logic [ORDER_W-1:0]   oo_r, oo_nxt;
  logic [CLASS_W-1:0]   oc_r, oc_nxt;
  logic                 ol_r, ol_nxt;
  logic [TOTAL_W-1:0]   ot_r, ot_nxt;
  logic                 ofv_r, ofv_nxt;
  logic [ADDR_BITS-1:0] ofb_r, ofb_nxt;
  logic [ORDER_W-1:0]   ofo_r, ofo_nxt;

  abp_pkg::blk_info_t   info;
  logic [ADDR_BITS-1:0] step_cur;
  logic [ADDR_BITS-1:0] step_rem;
  logic                 can_load;
  logic                 last_blk;

  assign d_in = q_rdata;

  abp_step #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_step (
    .cur      (cur_r),
    .rem      (rem_r),
    .main_min (main_min),
    .vice_min (vice_min),
    .info     (info),
    .nxt_cur  (step_cur),
    .nxt_rem  (step_rem)
  );

  assign can_load = !ov_r || out_ready;
  assign last_blk = ((emit_r + CNT_W'(1)) == n_r);
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  // Replay the cut and load the output register
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    rem_nxt      = rem_r;
    seg_base_nxt = seg_base_r;
    n_nxt        = n_r;
    emit_nxt     = emit_r;
    tot_nxt      = tot_r;
    bv_nxt       = bv_r;
    bb_nxt       = bb_r;
    bo_nxt       = bo_r;
    ov_nxt       = ov_r && !out_ready;
    ob_nxt       = ob_r;
    oo_nxt       = oo_r;
    oc_nxt       = oc_r;
    ol_nxt       = ol_r;
    ot_nxt       = ot_r;
    ofv_nxt      = ofv_r;
    ofb_nxt      = ofb_r;
    ofo_nxt      = ofo_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          cur_nxt      = d_in.base;
          rem_nxt      = d_in.rem;
          seg_base_nxt = d_in.base;
          n_nxt        = d_in.n_kept;
          emit_nxt     = '0;
          tot_nxt      = d_in.total;
          bv_nxt       = d_in.best_valid;
          bb_nxt       = d_in.best_base;
          bo_nxt       = d_in.best_order;
          state_nxt    = (d_in.n_kept == '0) ? B_NONE : B_WALK;
        end
      end
      B_NONE: begin
        // Nothing kept: one marker result at the segment base
        if (can_load) begin
          ov_nxt    = 1'b1;
          ob_nxt    = seg_base_r;
          oo_nxt    = '0;
          oc_nxt    = abp_pkg::CLS_NONE;
          ol_nxt    = 1'b1;
          ot_nxt    = tot_r;
          ofv_nxt   = bv_r;
          ofb_nxt   = bb_r;
          ofo_nxt   = bo_r;
          state_nxt = B_IDLE;
        end
      end
      B_WALK: begin
        if (can_load) begin
          if (info.cls != abp_pkg::CLS_NONE) begin
            ov_nxt   = 1'b1;
            ob_nxt   = cur_r;
            oo_nxt   = info.order;
            oc_nxt   = info.cls;
            ol_nxt   = last_blk;
            ot_nxt   = tot_r;
            ofv_nxt  = bv_r;
            ofb_nxt  = bb_r;
            ofo_nxt  = bo_r;
            emit_nxt = emit_r + 1'b1;
            if (last_blk) begin
              state_nxt = B_IDLE;
            end
          end
          cur_nxt = step_cur;
          rem_nxt = step_rem;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    rem_r      <= rem_nxt;
    seg_base_r <= seg_base_nxt;
    n_r        <= n_nxt;
    emit_r     <= emit_nxt;
    tot_r      <= tot_nxt;
    bv_r       <= bv_nxt;
    bb_r       <= bb_nxt;
    bo_r       <= bo_nxt;
    ob_r       <= ob_nxt;
    oo_r       <= oo_nxt;
    oc_r       <= oc_nxt;
    ol_r       <= ol_nxt;
    ot_r       <= ot_nxt;
    ofv_r      <= ofv_nxt;
    ofb_r      <= ofb_nxt;
    ofo_r      <= ofo_nxt;
  end

  assign out_valid   = ov_r;
  assign blk_base    = ob_r;
  assign blk_order   = oo_r;
  assign blk_class   = oc_r;
  assign blk_last    = ol_r;
  assign total_bytes = ot_r;
  assign first_valid = ofv_r;
  assign first_base  = ofb_r;
  assign first_order = ofo_r;

  `AST_ON(a_walk_fits, clk, rst_n, (state_r == B_WALK) |-> info.fits)
  `AST_ON(a_walk_count, clk, rst_n, (state_r == B_WALK) |-> (emit_r < n_r))
  `AST_ON(a_none_is_last, clk, rst_n, (ov_r && (oc_r == abp_pkg::CLS_NONE)) |-> ol_r)

endmodule

// ===== hdl/aligned_block_planner.sv =====
// ----------------------------------------------------------------------------
// aligned_block_planner
// Cuts free memory segments into naturally aligned power-of-two page blocks.
// ----------------------------------------------------------------------------
// Each accepted segment is planned by the front, which walks the blocks that
// the cut visits (one per cycle through the step unit, at most about 2 *
// (ADDR_BITS - PAGE_SHIFT) + 1 and never above 136 or past the 56th kept
// block); the front is ready for the next segment in the cycle after it
// hands its plan over. The back then replays the cut at one block per cycle
// while its output register can load and presents each kept block through
// that register, which loads a new block once its current one is taken; a
// segment that keeps nothing gives a single transfer with class 2. A two-entry
// plan queue lets the front take and plan the next segment while the back is
// still emitting, so throughput is set by the front while the back keeps up.
// Every transfer of a segment carries the byte total and smallest main block
// as they stand after that whole segment; both clear after a segment with
// in_tlast set. Write configuration only while no segment is in flight: both
// halves read the thresholds live.
// ----------------------------------------------------------------------------
module aligned_block_planner #(
  parameter int ADDR_BITS  = abp_pkg::ADDR_BITS_DEF,
  parameter int PAGE_SHIFT = abp_pkg::PAGE_SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port
  input  logic                          cfg_wr_en,
  input  logic [abp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abp_pkg::CFG_W-1:0]     cfg_wdata,
  // Segment input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // in_tdata: seg_base, seg_size (from bit 0 up), zero padded to bytes
  input  logic [((2*ADDR_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                          in_tlast,   // seg_last
  // Block output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_tdata: blk_base, blk_order, total_bytes, first_valid, first_base,
  //            first_order (from bit 0 up), zero padded to bytes
  output logic [((2*ADDR_BITS+2*abp_pkg::ORDER_W+abp_pkg::TOTAL_W+1+7)/8)*8-1:0] out_tdata,
  output logic [abp_pkg::CLASS_W-1:0]   out_tuser,  // blk_class
  output logic                          out_tlast   // last_of_segment
);

  localparam int ORDER_W    = abp_pkg::ORDER_W;
  localparam int TOTAL_W    = abp_pkg::TOTAL_W;
  localparam int CLASS_W    = abp_pkg::CLASS_W;
  localparam int CFG_W      = abp_pkg::CFG_W;
  localparam int OUT_DATA_W = ((2*ADDR_BITS + 2*ORDER_W + TOTAL_W + 1 + 7) / 8) * 8;
  localparam int DESC_W     = 3*ADDR_BITS + abp_pkg::CNT_W + TOTAL_W + 1 + ORDER_W;

  logic [CFG_W-1:0]     main_min_r;
  logic [CFG_W-1:0]     vice_min_r;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  logic [DESC_W-1:0]    q_wdata;
  logic [DESC_W-1:0]    q_rdata;

  logic [ADDR_BITS-1:0] blk_base;
  logic [ORDER_W-1:0]   blk_order;
  logic [CLASS_W-1:0]   blk_class;
  logic                 blk_last;
  logic [TOTAL_W-1:0]   total_bytes;
  logic                 first_valid;
  logic [ADDR_BITS-1:0] first_base;
  logic [ORDER_W-1:0]   first_order;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_min_r <= abp_pkg::MAIN_MIN_RST;
      vice_min_r <= abp_pkg::VICE_MIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        abp_pkg::CFG_MAIN_MIN: main_min_r <= cfg_wdata;
        abp_pkg::CFG_VICE_MIN: vice_min_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  abp_front #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_SHIFT (PAGE_SHIFT),
    .DESC_W     (DESC_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_valid (in_tvalid),
    .seg_ready (in_tready),
    .seg_base  (in_tdata[ADDR_BITS-1:0]),
    .seg_size  (in_tdata[2*ADDR_BITS-1:ADDR_BITS]),
    .seg_last  (in_tlast),
    .main_min  (main_min_r),
    .vice_min  (vice_min_r),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  abp_queue #(
    .WIDTH (DESC_W),
    .DEPTH (abp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  abp_back #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_SHIFT (PAGE_SHIFT),
    .DESC_W     (DESC_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_rdata     (q_rdata),
    .main_min    (main_min_r),
    .vice_min    (vice_min_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .blk_base    (blk_base),
    .blk_order   (blk_order),
    .blk_class   (blk_class),
    .blk_last    (blk_last),
    .total_bytes (total_bytes),
    .first_valid (first_valid),
    .first_base  (first_base),
    .first_order (first_order)
  );

  // Pack the result transfer
  assign out_tdata = OUT_DATA_W'({first_order, first_base, first_valid, total_bytes,
                                  blk_order, blk_base});
  assign out_tuser = blk_class;
  assign out_tlast = blk_last;

endmodule
